// ===== src/gbp_pkg.sv =====
`timescale 1ns / 1ps

package gbp_pkg;

    localparam int INDEX_BITS   = 12;
    localparam int TABLE_SIZE   = 1 << INDEX_BITS;
    localparam int TBL_IDX_W    = 12;
    localparam int HLEN_W       = 4;
    localparam int HSAT_W       = 5;
    localparam int CTR_W        = 2;
    localparam int TOTAL_W      = 32;
    localparam int ADDR_W       = 32;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [CTR_W-1:0]  CTR_RESET     = 2'd2;
    localparam logic [CTR_W-1:0]  CTR_MAX       = 2'd3;
    localparam logic [CTR_W-1:0]  CTR_MIN       = 2'd0;
    localparam logic [CTR_W-1:0]  CTR_TAKEN_MIN = 2'd2;
    localparam logic [HLEN_W-1:0] HLEN_RESET    = 4'd8;

    // register word index, taken from paddr[PADDR_W-1:2]
    localparam logic REG_HIST_LEN = 1'b0;

    typedef logic [INDEX_BITS-1:0] idx_t;
    typedef logic [CTR_W-1:0]      ctr_t;

endpackage

// ===== src/gshare_branch_predictor.sv =====
`timescale 1ns / 1ps

// gshare branch predictor, one resolved branch per transaction
// input channel s_*: branch address and actual outcome, valid/ready
// result channel m_*: prediction, mispredict flag, table index and the
// saturating mispredict count including this branch, valid/ready
// apb port: history_length at byte address 0, written in the access cycle
// m_valid rises once a branch has passed stage 1 and then the result register
// throughput: one branch per cycle unless the receiver stalls; the counter table
// is a synchronous memory with one read and one write port, read at acceptance
// and written back as stage 1 passes its branch to the result register, with the
// write forwarded when the next branch hits the same entry
// reset: after aresetn is released the table is swept to weakly taken,
// one entry per cycle over the whole table with s_ready low; apb writes are taken
// when the receiver stalls the result register holds and the pipeline
// fills, then s_ready drops until m_ready returns
module gshare_branch_predictor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [gbp_pkg::ADDR_W-1:0]    s_branch_address,
    input  logic                          s_outcome_taken,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_prediction_taken,
    output logic                          m_mispredicted,
    output logic [gbp_pkg::TBL_IDX_W-1:0] m_table_index,
    output logic [gbp_pkg::TOTAL_W-1:0]   m_mispredict_total,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gbp_pkg::PADDR_W-1:0]   paddr,
    input  logic [gbp_pkg::PDATA_W-1:0]   pwdata,
    output logic [gbp_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int IB = gbp_pkg::INDEX_BITS;

    // configuration
    logic [gbp_pkg::HLEN_W-1:0] hist_len_reg;
    logic                       cfg_sel;

    // clearing sweep
    logic          clr_busy_reg;
    gbp_pkg::idx_t clr_idx_reg;

    // history and index
    logic [IB-1:0]              hist_reg;
    logic [IB-1:0]              hist_next;
    logic [gbp_pkg::HSAT_W-1:0] h_sat;
    logic [IB-1:0]              hmask;
    gbp_pkg::idx_t              idx_in;
    logic                       accept;

    // stage 1
    logic          s1_valid_reg;
    gbp_pkg::idx_t s1_idx_reg;
    logic          s1_taken_reg;
    logic          fwd_hit_reg;
    gbp_pkg::ctr_t fwd_data_reg;
    gbp_pkg::ctr_t rd_data_reg;
    gbp_pkg::ctr_t s1_ctr;
    gbp_pkg::ctr_t s1_ctr_new;
    logic          s1_pred;
    logic          s1_miss;
    logic          s1_go;

    logic [gbp_pkg::TOTAL_W-1:0] miss_cnt_reg;
    logic [gbp_pkg::TOTAL_W-1:0] miss_cnt_next;

    // memory
    gbp_pkg::ctr_t mem [gbp_pkg::TABLE_SIZE];
    logic          mem_we;
    gbp_pkg::idx_t mem_waddr;
    gbp_pkg::ctr_t mem_wdata;

    // result register
    logic                          m_valid_reg;
    logic                          m_pred_reg;
    logic                          m_miss_reg;
    logic [gbp_pkg::TBL_IDX_W-1:0] m_idx_reg;
    logic [gbp_pkg::TOTAL_W-1:0]   m_total_reg;

    // apb
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[gbp_pkg::PADDR_W-1:2] == gbp_pkg::REG_HIST_LEN);
    assign prdata  = cfg_sel ? gbp_pkg::PDATA_W'(hist_len_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_len_reg <= gbp_pkg::HLEN_RESET;
        end else if (psel && penable && pwrite && cfg_sel) begin
            hist_len_reg <= pwdata[gbp_pkg::HLEN_W-1:0];
        end
    end

    // index
    always_comb begin
        if (gbp_pkg::HSAT_W'(hist_len_reg) > gbp_pkg::HSAT_W'(IB)) begin
            h_sat = gbp_pkg::HSAT_W'(IB);
        end else begin
            h_sat = gbp_pkg::HSAT_W'(hist_len_reg);
        end
        for (int i = 0; i < IB; i++) begin
            hmask[i] = ((32'(h_sat) + 32'(i)) >= 32'(IB));
        end
        idx_in = s_branch_address[IB+1:2] ^ (hist_reg & hmask);
        hist_next = hist_reg >> 1;
        hist_next[IB-1] = s_outcome_taken;
    end

    assign s1_go   = !m_valid_reg || m_ready;
    assign s_ready = !clr_busy_reg && (!s1_valid_reg || s1_go);
    assign accept  = s_valid && s_ready;

    // stage 1 counter update
    always_comb begin
        s1_ctr  = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        s1_pred = (s1_ctr >= gbp_pkg::CTR_TAKEN_MIN);
        s1_miss = (s1_pred != s1_taken_reg);
        s1_ctr_new = s1_ctr;
        if (s1_taken_reg) begin
            if (s1_ctr != gbp_pkg::CTR_MAX) begin
                s1_ctr_new = s1_ctr + gbp_pkg::CTR_W'(1);
            end
        end else begin
            if (s1_ctr != gbp_pkg::CTR_MIN) begin
                s1_ctr_new = s1_ctr - gbp_pkg::CTR_W'(1);
            end
        end
        miss_cnt_next = miss_cnt_reg;
        if (s1_miss && (miss_cnt_reg != '1)) begin
            miss_cnt_next = miss_cnt_reg + gbp_pkg::TOTAL_W'(1);
        end
    end

    // memory write port: sweep or write-back
    always_comb begin
        if (clr_busy_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = gbp_pkg::CTR_RESET;
        end else begin
            mem_we    = s1_valid_reg && s1_go;
            mem_waddr = s1_idx_reg;
            mem_wdata = s1_ctr_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            rd_data_reg <= mem[idx_in];
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
            hist_reg     <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            miss_cnt_reg <= '0;
        end else begin
            if (clr_busy_reg) begin
                clr_idx_reg <= clr_idx_reg + IB'(1);
                if (clr_idx_reg == '1) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (accept) begin
                hist_reg <= hist_next;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_go) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_valid_reg && s1_go) begin
                m_valid_reg  <= 1'b1;
                miss_cnt_reg <= miss_cnt_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_idx_reg   <= idx_in;
            s1_taken_reg <= s_outcome_taken;
            fwd_hit_reg  <= s1_valid_reg && (s1_idx_reg == idx_in);
            fwd_data_reg <= s1_ctr_new;
        end
        if (s1_valid_reg && s1_go) begin
            m_pred_reg  <= s1_pred;
            m_miss_reg  <= s1_miss;
            m_idx_reg   <= gbp_pkg::TBL_IDX_W'(s1_idx_reg);
            m_total_reg <= miss_cnt_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_prediction_taken = m_pred_reg;
    assign m_mispredicted     = m_miss_reg;
    assign m_table_index      = m_idx_reg;
    assign m_mispredict_total = m_total_reg;

endmodule

// ===== src/gbp_checker.sv =====
`timescale 1ns / 1ps

module gbp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_prediction_taken,
    input logic                          m_mispredicted,
    input logic [gbp_pkg::TBL_IDX_W-1:0] m_table_index,
    input logic [gbp_pkg::TOTAL_W-1:0]   m_mispredict_total
);

    // stalled result transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_prediction_taken)
            && $stable(m_mispredicted) && $stable(m_table_index)
            && $stable(m_mispredict_total))
        else $error("stalled result changed");

    // table sweep keeps the input closed and no result out right after reset
    assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> !s_ready && !m_valid)
        else $error("activity right after reset");

    // a mispredict is always counted
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_mispredicted |-> m_mispredict_total != '0)
        else $error("mispredict not counted");

    // no result without an earlier input transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2) || $past(m_valid))
        else $error("result without input");

endmodule

bind gshare_branch_predictor gbp_checker u_gbp_checker (.*);

// ===== tb/tb_gshare_branch_predictor.sv =====
`timescale 1ns / 1ps

module tb_gshare_branch_predictor;

    localparam logic [gbp_pkg::PADDR_W-3:0] REG_SPARE = 1'b1;
    localparam int RANDOM_ITEMS = 1250;
    localparam int PHASES       = 5;
    localparam int HOT_COUNT    = 8;

    typedef enum logic [1:0] {ROW_BRANCH, ROW_WRITE, ROW_READ} row_kind_t;

    typedef struct packed {
        logic                          prediction_taken;
        logic                          mispredicted;
        logic [gbp_pkg::TBL_IDX_W-1:0] table_index;
        logic [gbp_pkg::TOTAL_W-1:0]   mispredict_total;
    } branch_res_t;

    typedef struct packed {
        row_kind_t                   kind;
        logic [gbp_pkg::PADDR_W-3:0] reg_sel;
        logic [gbp_pkg::ADDR_W-1:0]  value;
        logic                        taken;
        logic                        typed;
        branch_res_t                 res;
    } dir_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [gbp_pkg::ADDR_W-1:0]    s_branch_address;
    logic                          s_outcome_taken;
    logic                          m_valid;
    logic                          m_ready;
    logic                          m_prediction_taken;
    logic                          m_mispredicted;
    logic [gbp_pkg::TBL_IDX_W-1:0] m_table_index;
    logic [gbp_pkg::TOTAL_W-1:0]   m_mispredict_total;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [gbp_pkg::PADDR_W-1:0]   paddr;
    logic [gbp_pkg::PDATA_W-1:0]   pwdata;
    logic [gbp_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    gshare_branch_predictor uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_branch_address   (s_branch_address),
        .s_outcome_taken    (s_outcome_taken),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_prediction_taken (m_prediction_taken),
        .m_mispredicted     (m_mispredicted),
        .m_table_index      (m_table_index),
        .m_mispredict_total (m_mispredict_total),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // shadow of the predictor state
    gbp_pkg::ctr_t               counters [gbp_pkg::TABLE_SIZE];
    gbp_pkg::idx_t               ghist;
    logic [gbp_pkg::TOTAL_W-1:0] miss_total;
    logic [gbp_pkg::HLEN_W-1:0]  hist_len;

    branch_res_t        pending_results [$];
    int                 mismatch_count;
    logic               cur_typed;
    branch_res_t        cur_typed_res;

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    task automatic gshare_update(input logic [gbp_pkg::ADDR_W-1:0] a, input logic t,
                                 output branch_res_t r);
        int            h;
        gbp_pkg::idx_t msk;
        gbp_pkg::idx_t ix;
        gbp_pkg::ctr_t c;
        h = (hist_len > gbp_pkg::INDEX_BITS) ? gbp_pkg::INDEX_BITS : int'(hist_len);
        for (int b = 0; b < gbp_pkg::INDEX_BITS; b++)
            msk[b] = (b >= gbp_pkg::INDEX_BITS - h);
        ix = a[gbp_pkg::INDEX_BITS+1:2] ^ (ghist & msk);
        c = counters[ix];
        r.prediction_taken = (c >= gbp_pkg::CTR_TAKEN_MIN);
        r.mispredicted = (r.prediction_taken != t);
        if (t && c != gbp_pkg::CTR_MAX)
            c = c + 1'b1;
        else if (!t && c != gbp_pkg::CTR_MIN)
            c = c - 1'b1;
        counters[ix] = c;
        if (r.mispredicted && miss_total != '1)
            miss_total = miss_total + 1'b1;
        // newest outcome enters at the top bit
        ghist = {t, ghist[gbp_pkg::INDEX_BITS-1:1]};
        r.table_index = gbp_pkg::TBL_IDX_W'(ix);
        r.mispredict_total = miss_total;
    endtask

    always @(posedge aclk) begin
        branch_res_t e;
        if (aresetn) begin
            if (psel && penable && pready &&
                paddr[gbp_pkg::PADDR_W-1:2] == gbp_pkg::REG_HIST_LEN) begin
                if (pwrite) begin
                    hist_len = pwdata[gbp_pkg::HLEN_W-1:0];
                end else if (prdata !== gbp_pkg::PDATA_W'(hist_len)) begin
                    $error("prdata expected %0d got %0d", hist_len, prdata);
                    mismatch_count++;
                end
            end
            if (s_valid && s_ready) begin
                gshare_update(s_branch_address, s_outcome_taken, e);
                if (cur_typed)
                    e = cur_typed_res;
                pending_results.insert(pending_results.size(), e);
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with none outstanding");
                    mismatch_count++;
                end else begin
                    e = pending_results.pop_front();
                    if (m_prediction_taken !== e.prediction_taken) begin
                        $error("prediction_taken expected %0d got %0d",
                               e.prediction_taken, m_prediction_taken);
                        mismatch_count++;
                    end
                    if (m_mispredicted !== e.mispredicted) begin
                        $error("mispredicted expected %0d got %0d",
                               e.mispredicted, m_mispredicted);
                        mismatch_count++;
                    end
                    if (m_table_index !== e.table_index) begin
                        $error("table_index expected 0x%03h got 0x%03h",
                               e.table_index, m_table_index);
                        mismatch_count++;
                    end
                    if (m_mispredict_total !== e.mispredict_total) begin
                        $error("mispredict_total expected %0d got %0d",
                               e.mispredict_total, m_mispredict_total);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // receiver back-pressure, changes character now and then
    initial begin
        int mode;
        int span;
        m_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic send_branch(input logic [gbp_pkg::ADDR_W-1:0] a, input logic t,
                               input logic typed, input branch_res_t tv);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_branch_address <= a;
        s_outcome_taken <= t;
        cur_typed = typed;
        cur_typed_res = tv;
        forever begin
            @(posedge aclk);
            if (s_ready)
                break;
        end
    endtask

    task automatic idle(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    task automatic drain();
        idle(1);
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [gbp_pkg::PADDR_W-3:0] sel,
                            input logic [gbp_pkg::PDATA_W-1:0] d);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {sel, 2'b00};
        pwdata <= d;
        @(negedge aclk);
        penable <= 1'b1;
        forever begin
            @(posedge aclk);
            if (pready)
                break;
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic dir_row_t branch_row(input logic [gbp_pkg::ADDR_W-1:0] a,
                                            input logic t);
        dir_row_t r;
        r = '0;
        r.kind = ROW_BRANCH;
        r.value = a;
        r.taken = t;
        return r;
    endfunction

    function automatic dir_row_t checked_row(input logic [gbp_pkg::ADDR_W-1:0] a,
                                             input logic t,
                                             input logic p, input logic m,
                                             input logic [gbp_pkg::TBL_IDX_W-1:0] ix,
                                             input logic [gbp_pkg::TOTAL_W-1:0] tot);
        dir_row_t r;
        r = branch_row(a, t);
        r.typed = 1'b1;
        r.res.prediction_taken = p;
        r.res.mispredicted = m;
        r.res.table_index = ix;
        r.res.mispredict_total = tot;
        return r;
    endfunction

    function automatic dir_row_t reg_row(input row_kind_t kind,
                                         input logic [gbp_pkg::PADDR_W-3:0] sel,
                                         input logic [gbp_pkg::PDATA_W-1:0] d);
        dir_row_t r;
        r = '0;
        r.kind = kind;
        r.reg_sel = sel;
        r.value = d;
        return r;
    endfunction

    initial begin
        dir_row_t                   rows [$];
        dir_row_t                   rw;
        logic [gbp_pkg::ADDR_W-1:0] hot_addr [HOT_COUNT];
        int                         hot_bias [HOT_COUNT];
        int                         burst;
        int                         k;
        logic [gbp_pkg::ADDR_W-1:0] a;
        logic                       t;
        logic [gbp_pkg::HLEN_W-1:0] phase_len;

        s_valid = 1'b0;
        s_branch_address = '0;
        s_outcome_taken = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_typed = 1'b0;
        cur_typed_res = '0;
        mismatch_count = 0;
        foreach (counters[i])
            counters[i] = gbp_pkg::CTR_RESET;
        ghist = '0;
        miss_total = '0;
        hist_len = gbp_pkg::HLEN_RESET;
        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // all counters weakly taken, history clear
        rows.insert(rows.size(), checked_row(32'h0000_0000, 1'b0, 1'b1, 1'b1, 12'h000, 32'd1));
        rows.insert(rows.size(), checked_row(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 12'hFFF, 32'd1));
        rows.insert(rows.size(), branch_row(32'hFFFF_FFFC, 1'b1));
        rows.insert(rows.size(), branch_row(32'h0000_0004, 1'b1));
        rows.insert(rows.size(), branch_row(32'h0000_0004, 1'b0));
        rows.insert(rows.size(), reg_row(ROW_READ, gbp_pkg::REG_HIST_LEN, '0));
        // no history: one entry saturates up then down
        rows.insert(rows.size(), reg_row(ROW_WRITE, gbp_pkg::REG_HIST_LEN, 32'd0));
        rows.insert(rows.size(), reg_row(ROW_READ, gbp_pkg::REG_HIST_LEN, '0));
        repeat (3) rows.insert(rows.size(), branch_row(32'h0000_1000, 1'b1));
        repeat (4) rows.insert(rows.size(), branch_row(32'h0000_1000, 1'b0));
        rows.insert(rows.size(), branch_row(32'h0000_1000, 1'b1));
        // history length beyond the index width
        rows.insert(rows.size(), reg_row(ROW_WRITE, gbp_pkg::REG_HIST_LEN, 32'd15));
        rows.insert(rows.size(), reg_row(ROW_READ, gbp_pkg::REG_HIST_LEN, '0));
        rows.insert(rows.size(), branch_row(32'h8000_0000, 1'b1));
        rows.insert(rows.size(), branch_row(32'h7FFF_FFFC, 1'b0));
        rows.insert(rows.size(), branch_row(32'h1234_5678, 1'b1));
        rows.insert(rows.size(), reg_row(ROW_WRITE, gbp_pkg::REG_HIST_LEN, 32'd12));
        rows.insert(rows.size(), branch_row(32'hAAAA_AAA8, 1'b1));
        rows.insert(rows.size(), branch_row(32'h5555_5554, 1'b0));
        rows.insert(rows.size(), branch_row(32'hFFFF_FFFF, 1'b0));
        // unmapped register must leave the history length alone
        rows.insert(rows.size(), reg_row(ROW_WRITE, REG_SPARE, 32'hFFFF_FFFF));
        rows.insert(rows.size(), reg_row(ROW_READ, gbp_pkg::REG_HIST_LEN, '0));
        rows.insert(rows.size(), branch_row(32'h0000_0ABC, 1'b1));

        foreach (rows[i]) begin
            rw = rows[i];
            if (rw.kind == ROW_BRANCH) begin
                send_branch(rw.value, rw.taken, rw.typed, rw.res);
                if ($urandom_range(0, 2) == 0)
                    idle($urandom_range(1, 3));
            end else begin
                drain();
                apb_xfer(rw.kind == ROW_WRITE, rw.reg_sel, rw.value);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: phase_len = 4'd12;
                1: phase_len = 4'd15;
                2: phase_len = 4'd0;
                3: phase_len = 4'd1;
                default: phase_len = gbp_pkg::HLEN_W'($urandom_range(0, 15));
            endcase
            drain();
            apb_xfer(1'b1, REG_SPARE, $urandom);
            apb_xfer(1'b1, gbp_pkg::REG_HIST_LEN, gbp_pkg::PDATA_W'(phase_len));
            apb_xfer(1'b0, gbp_pkg::REG_HIST_LEN, '0);
            // a handful of hot branches with their own bias
            foreach (hot_addr[i]) begin
                hot_addr[i] = $urandom;
                hot_bias[i] = $urandom_range(0, 100);
            end
            burst = $urandom_range(1, 40);
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                if ($urandom_range(0, 9) < 7) begin
                    k = $urandom_range(0, HOT_COUNT - 1);
                    a = hot_addr[k];
                    t = ($urandom_range(0, 99) < hot_bias[k]);
                end else begin
                    a = $urandom;
                    t = 1'($urandom_range(0, 1));
                end
                send_branch(a, t, 1'b0, '0);
                burst--;
                if (burst == 0) begin
                    if ($urandom_range(0, 19) == 0)
                        drain();
                    else
                        idle($urandom_range(1, 12));
                    burst = $urandom_range(1, 40);
                end
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
